@@ src/rgb_color_effect_unit_macros.svh @@
// Assertion macros for the RGB color effect unit
`ifndef RGB_COLOR_EFFECT_UNIT_MACROS_SVH
`define RGB_COLOR_EFFECT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define RCE_ASSERT_SAME(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("rce assertion failed");
// next-cycle implication, disabled in reset
`define RCE_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("rce assertion failed");
`else
`define RCE_ASSERT_SAME(lbl, ck, rn, pre, post)
`define RCE_ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif

`endif

@@ src/rce_pkg.sv @@
// Package: codes, coefficients and fixed-point constants of the RGB effect unit
`timescale 1ns / 1ps

package rce_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned NUM_CH = 3;

  // configuration register indexes (paddr[2])
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_VALUE = 1'b1;

  // effect codes
  localparam logic [2:0] MODE_SEPIA  = 3'd0;
  localparam logic [2:0] MODE_GRAY   = 3'd1;
  localparam logic [2:0] MODE_INVERT = 3'd2;
  localparam logic [2:0] MODE_THRESH = 3'd3;
  localparam logic [2:0] MODE_POSTER = 3'd4;

  // sepia matrix in Q0.16, [output channel][input channel]
  localparam logic [15:0] SEP_COEF [NUM_CH][NUM_CH] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  // Rec.709 luma in Q0.16, sums to exactly 1.0
  localparam logic [15:0] LUM_COEF [NUM_CH] = '{16'd13933, 16'd46871, 16'd4732};

  // sepia blend: num = c*(100-f)<<16 + S*f + half, divided by 100<<16
  localparam logic [30:0] SEP_HALF     = 31'd3276800;
  localparam logic [23:0] SEP_LIMIT    = 24'hFF_0000;
  localparam logic [6:0]  SEP_PCT_MAX  = 7'd100;
  // ceil(2^22/100), exact for dividends below 2^15
  localparam logic [15:0] DIV100_MUL   = 16'd41944;

  // posterize: ceil(2^26/510), exact for dividends below 2^17
  localparam logic [17:0] DIV510_MUL   = 18'd131587;
  localparam int unsigned POST_SHIFT   = 26;
  localparam logic [8:0]  POST_SCALE   = 9'd510;
  localparam logic [7:0]  POST_ROUND   = 8'd255;

endpackage

@@ src/rgb_color_effect_unit.sv @@
// RGB color effect unit: 4-stage pipeline of sepia, gray, invert, threshold, posterize
// Stage 1 loads at the accepting edge, then stages 2, 3 and the output register
//   follow up to out_valid; throughput one pixel per cycle while out_stall is low.
// Each stage holds its request until the next stage frees, so a stalled output lets
//   bubbles close up behind it. Synchronous active-low reset clears valid bits and the
//   mode and value registers (sepia mode, value 0); no clearing pass is needed.
`timescale 1ns / 1ps

`include "rgb_color_effect_unit_macros.svh"

module rgb_color_effect_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // pixel input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rce_pkg::CHAN_W-1:0] in_red_in,
  input  logic [rce_pkg::CHAN_W-1:0] in_green_in,
  input  logic [rce_pkg::CHAN_W-1:0] in_blue_in,
  input  logic [rce_pkg::CHAN_W-1:0] in_alpha_in,
  // pixel output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rce_pkg::CHAN_W-1:0] out_red_out,
  output logic [rce_pkg::CHAN_W-1:0] out_green_out,
  output logic [rce_pkg::CHAN_W-1:0] out_blue_out,
  output logic [rce_pkg::CHAN_W-1:0] out_alpha_out
);

  import rce_pkg::*;

  // ---------------- configuration ----------------
  logic [2:0]  mode_r;
  logic [7:0]  value_r;
  logic [6:0]  pct_r;     // sepia intensity, saturated at 100
  logic [7:0]  lvl_n_r;   // posterize levels minus one, 1..254
  logic [25:0] recip_r;   // ceil(2^26 / (2*n))
  logic        cfg_wr;
  logic [7:0]  lvl_n_nxt;
  logic [6:0]  pct_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SEPIA;
      value_r <= 8'd0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MODE:  mode_r  <= pwdata[2:0];
        REG_VALUE: value_r <= pwdata[7:0];
        default:   mode_r  <= mode_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = {29'd0, mode_r};
      REG_VALUE: prdata = {24'd0, value_r};
      default:   prdata = 32'd0;
    endcase
  end

  // posterize reciprocal table, one entry per level-minus-one count
  logic [25:0] recip_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_recip
    localparam int unsigned Div = (gi < 2) ? 2 : 2 * gi;
    localparam int unsigned Mul = ((2 ** POST_SHIFT) + Div - 1) / Div;
    assign recip_tab[gi] = 26'(Mul);
  end

  // derived settings, loaded together with the value register so stage 1 sees them
  // on the next pixel; the reciprocal is registered the cycle after, first read in stage 4
  assign pct_nxt   = (pwdata[7:0] > 8'(SEP_PCT_MAX)) ? SEP_PCT_MAX : pwdata[6:0];
  assign lvl_n_nxt = (pwdata[7:0] < 8'd2) ? 8'd1 : (pwdata[7:0] - 8'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r   <= 7'd0;
      lvl_n_r <= 8'd1;
      recip_r <= recip_tab[1];
    end else begin
      if (cfg_wr && paddr[2] == REG_VALUE) begin
        pct_r   <= pct_nxt;
        lvl_n_r <= lvl_n_nxt;
      end
      recip_r <= recip_tab[lvl_n_r];
    end
  end

  // ---------------- handshake chain ----------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy  = !out_valid_r || !out_stall;
  assign s3_rdy   = !s3_valid_r || out_rdy;
  assign s2_rdy   = !s2_valid_r || s3_rdy;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_stall = !s1_rdy;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_valid_r  <= in_valid;
      if (s2_rdy)  s2_valid_r  <= s1_valid_r;
      if (s3_rdy)  s3_valid_r  <= s2_valid_r;
      if (out_rdy) out_valid_r <= s3_valid_r;
    end
  end

  // ---------------- stage 1: matrix sums, luma, posterize numerator ----------------
  logic [7:0]  in_c [NUM_CH];
  logic [24:0] sep_sum_nxt [NUM_CH];
  logic [23:0] luma_nxt;
  logic [16:0] pnum_nxt [NUM_CH];

  assign in_c[0] = in_red_in;
  assign in_c[1] = in_green_in;
  assign in_c[2] = in_blue_in;

  always_comb begin
    luma_nxt = 24'd0;
    for (int o = 0; o < NUM_CH; o++) begin
      sep_sum_nxt[o] = 25'(in_c[0]) * 25'(SEP_COEF[o][0])
                     + 25'(in_c[1]) * 25'(SEP_COEF[o][1])
                     + 25'(in_c[2]) * 25'(SEP_COEF[o][2]);
      luma_nxt       = luma_nxt + 24'(in_c[o]) * 24'(LUM_COEF[o]);
      // 2*c*n + 255
      pnum_nxt[o]    = {16'(in_c[o]) * 16'(lvl_n_r), 1'b0} + 17'(POST_ROUND);
    end
  end

  logic [7:0]  s1_c_r    [NUM_CH];
  logic [7:0]  s1_alpha_r;
  logic [24:0] s1_sep_r  [NUM_CH];
  logic [23:0] s1_luma_r;
  logic [16:0] s1_pnum_r [NUM_CH];

  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) begin
      s1_c_r     <= in_c;
      s1_alpha_r <= in_alpha_in;
      s1_sep_r   <= sep_sum_nxt;
      s1_luma_r  <= luma_nxt;
      s1_pnum_r  <= pnum_nxt;
    end
  end

  // ---------------- stage 2: sepia blend, posterize level index, gray ----------------
  logic [23:0] sep_clip;
  logic [30:0] blend;
  logic [34:0] kprod;
  logic [24:0] gray_sum;
  logic [14:0] q16_nxt [NUM_CH];
  logic [7:0]  k_nxt   [NUM_CH];
  logic [7:0]  gray_nxt;
  logic        thr_nxt;

  always_comb begin
    sep_clip = 24'd0;
    blend    = 31'd0;
    kprod    = 35'd0;
    for (int o = 0; o < NUM_CH; o++) begin
      sep_clip   = (s1_sep_r[o] > 25'(SEP_LIMIT)) ? SEP_LIMIT : s1_sep_r[o][23:0];
      blend      = {15'(s1_c_r[o]) * 15'(SEP_PCT_MAX - pct_r), 16'd0}
                 + 31'(sep_clip) * 31'(pct_r) + SEP_HALF;
      q16_nxt[o] = blend[30:16];
      // floor((2cn+255)/510)
      kprod      = 35'(s1_pnum_r[o]) * 35'(DIV510_MUL);
      k_nxt[o]   = kprod[POST_SHIFT+7:POST_SHIFT];
    end
    gray_sum = 25'(s1_luma_r) + 25'd32768;
    gray_nxt = gray_sum[23:16];
    thr_nxt  = s1_luma_r >= {value_r, 16'd0};
  end

  logic [7:0]  s2_c_r   [NUM_CH];
  logic [7:0]  s2_alpha_r;
  logic [14:0] s2_q16_r [NUM_CH];
  logic [7:0]  s2_k_r   [NUM_CH];
  logic [7:0]  s2_gray_r;
  logic        s2_thr_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_rdy) begin
      s2_c_r     <= s1_c_r;
      s2_alpha_r <= s1_alpha_r;
      s2_q16_r   <= q16_nxt;
      s2_k_r     <= k_nxt;
      s2_gray_r  <= gray_nxt;
      s2_thr_r   <= thr_nxt;
    end
  end

  // ---------------- stage 3: divide by 100, posterize second numerator ----------------
  logic [30:0] dprod;
  logic [7:0]  sep_nxt  [NUM_CH];
  logic [16:0] pnum2_nxt [NUM_CH];

  always_comb begin
    dprod = 31'd0;
    for (int o = 0; o < NUM_CH; o++) begin
      dprod        = 31'(s2_q16_r[o]) * 31'(DIV100_MUL);
      sep_nxt[o]   = dprod[29:22];
      // 510*k + n
      pnum2_nxt[o] = 17'(s2_k_r[o]) * 17'(POST_SCALE) + 17'(lvl_n_r);
    end
  end

  logic [7:0]  s3_c_r     [NUM_CH];
  logic [7:0]  s3_alpha_r;
  logic [7:0]  s3_sep_r   [NUM_CH];
  logic [16:0] s3_pnum2_r [NUM_CH];
  logic [7:0]  s3_gray_r;
  logic        s3_thr_r;

  always_ff @(posedge clk) begin
    if (s2_valid_r && s3_rdy) begin
      s3_c_r     <= s2_c_r;
      s3_alpha_r <= s2_alpha_r;
      s3_sep_r   <= sep_nxt;
      s3_pnum2_r <= pnum2_nxt;
      s3_gray_r  <= s2_gray_r;
      s3_thr_r   <= s2_thr_r;
    end
  end

  // ---------------- stage 4: posterize divide by 2n, effect select ----------------
  logic [42:0] pprod;
  logic [7:0]  post_val;
  logic [7:0]  res_nxt [NUM_CH];

  always_comb begin
    pprod    = 43'd0;
    post_val = 8'd0;
    for (int o = 0; o < NUM_CH; o++) begin
      pprod    = 43'(s3_pnum2_r[o]) * 43'(recip_r);
      post_val = pprod[POST_SHIFT+7:POST_SHIFT];
      case (mode_r)
        MODE_SEPIA:  res_nxt[o] = s3_sep_r[o];
        MODE_GRAY:   res_nxt[o] = s3_gray_r;
        MODE_INVERT: res_nxt[o] = ~s3_c_r[o];
        MODE_THRESH: res_nxt[o] = s3_thr_r ? 8'hFF : 8'h00;
        MODE_POSTER: res_nxt[o] = post_val;
        default:     res_nxt[o] = s3_c_r[o];
      endcase
    end
  end

  logic [7:0] out_c_r [NUM_CH];
  logic [7:0] out_alpha_r;
  logic       out_load;

  assign out_load = s3_valid_r && out_rdy;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_c_r     <= res_nxt;
      out_alpha_r <= s3_alpha_r;
    end
  end

  assign out_red_out   = out_c_r[0];
  assign out_green_out = out_c_r[1];
  assign out_blue_out  = out_c_r[2];
  assign out_alpha_out = out_alpha_r;

  // ---------------- assertions ----------------
  // an empty output register never pushes back on the input
  `RCE_ASSERT_SAME(a_no_stall_when_empty, clk, rst_n, !out_valid_r, !in_stall)
  // gray and threshold results are neutral
  `RCE_ASSERT_NEXT(a_neutral_gray, clk, rst_n,
                   out_load && (mode_r == MODE_GRAY || mode_r == MODE_THRESH),
                   out_c_r[0] == out_c_r[1] && out_c_r[1] == out_c_r[2])
  // threshold gives only black or white
  `RCE_ASSERT_NEXT(a_thresh_binary, clk, rst_n, out_load && mode_r == MODE_THRESH,
                   out_c_r[0] == 8'h00 || out_c_r[0] == 8'hFF)

endmodule

@@ dv/rgb_effect_checker.sv @@
// Checker for the RGB effect unit: tracks the effect registers, predicts and compares pixels
`timescale 1ns / 1ps

module rgb_effect_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_alpha_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_red_out,
  input  logic [7:0]  out_green_out,
  input  logic [7:0]  out_blue_out,
  input  logic [7:0]  out_alpha_out,
  output int          error_count,
  output int          pending_count,
  output int          pixel_count
);
  import rce_pkg::*;

  typedef longint unsigned wide_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    pixel_t     src;
    pixel_t     want;
    logic [2:0] mode;
    logic [7:0] level;
  } shaded_t;

  // sepia matrix, Q0.16, output channel first
  localparam wide_t TONE_RR = 25756;
  localparam wide_t TONE_RG = 50397;
  localparam wide_t TONE_RB = 12386;
  localparam wide_t TONE_GR = 22872;
  localparam wide_t TONE_GG = 44958;
  localparam wide_t TONE_GB = 11010;
  localparam wide_t TONE_BR = 17826;
  localparam wide_t TONE_BG = 34996;
  localparam wide_t TONE_BB = 8585;
  localparam wide_t TONE_CAP = 255 << 16;
  // Rec.709 luma, Q0.16
  localparam wide_t LUMA_R = 13933;
  localparam wide_t LUMA_G = 46871;
  localparam wide_t LUMA_B = 4732;

  logic [2:0] fx_mode;
  logic [7:0] fx_value;
  shaded_t    shaded_q[$];

  // blend one channel with its clamped sepia sum, weight f percent, round half up
  function automatic wide_t tone_blend(wide_t c, wide_t s, wide_t f);
    wide_t s_lim;
    s_lim = (s > TONE_CAP) ? TONE_CAP : s;
    return (c * (100 - f) * 65536 + s_lim * f + 3276800) / 6553600;
  endfunction

  // snap a channel to the nearest of n+1 evenly spaced levels
  function automatic wide_t quant_level(wide_t c, wide_t n);
    wide_t k;
    k = (2 * c * n + 255) / 510;
    return (2 * k * 255 + n) / (2 * n);
  endfunction

  function automatic pixel_t apply_effect(pixel_t px, logic [2:0] mode, logic [7:0] level);
    wide_t  r, g, b, v, y, f, n;
    pixel_t res;
    r = wide_t'(px.red);
    g = wide_t'(px.green);
    b = wide_t'(px.blue);
    v = wide_t'(level);
    res = px;
    y = r * LUMA_R + g * LUMA_G + b * LUMA_B;
    case (mode)
      MODE_SEPIA: begin
        f = (v > 100) ? 100 : v;
        res.red   = 8'(tone_blend(r, r * TONE_RR + g * TONE_RG + b * TONE_RB, f));
        res.green = 8'(tone_blend(g, r * TONE_GR + g * TONE_GG + b * TONE_GB, f));
        res.blue  = 8'(tone_blend(b, r * TONE_BR + g * TONE_BG + b * TONE_BB, f));
      end
      MODE_GRAY: begin
        y = (y + 32768) >> 16;
        if (y > 255) y = 255;
        res.red   = 8'(y);
        res.green = 8'(y);
        res.blue  = 8'(y);
      end
      MODE_INVERT: begin
        res.red   = 8'd255 - px.red;
        res.green = 8'd255 - px.green;
        res.blue  = 8'd255 - px.blue;
      end
      MODE_THRESH: begin
        // compare unrounded luma against the threshold
        res.red   = (y >= (v << 16)) ? 8'hFF : 8'h00;
        res.green = res.red;
        res.blue  = res.red;
      end
      MODE_POSTER: begin
        // fewer than two levels act as two
        n = (v < 2) ? 1 : v - 1;
        res.red   = 8'(quant_level(r, n));
        res.green = 8'(quant_level(g, n));
        res.blue  = 8'(quant_level(b, n));
      end
      default: ;  // spare modes pass RGB through
    endcase
    return res;
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    shaded_t     head;
    pixel_t      got;
    logic [31:0] reg_val;
    if (!rst_n) begin
      fx_mode     = MODE_SEPIA;
      fx_value    = '0;
      error_count = 0;
      pixel_count = 0;
      shaded_q.delete();
    end else begin
      // register requests: writes update the shadow copy, reads are checked against it
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_VALUE) fx_value = pwdata[7:0];
          else fx_mode = pwdata[2:0];
        end else begin
          reg_val = (paddr[2] == REG_VALUE) ? {24'd0, fx_value} : {29'd0, fx_mode};
          if (prdata !== reg_val)
            note_failure($sformatf("readback addr %0d exp %h got %h", paddr, reg_val, prdata));
        end
      end

      // accepted pixel: predict with the current effect setting
      if (in_valid && !in_stall) begin
        head.src   = {in_red_in, in_green_in, in_blue_in, in_alpha_in};
        head.mode  = fx_mode;
        head.level = fx_value;
        head.want  = apply_effect(head.src, fx_mode, fx_value);
        shaded_q.push_back(head);
      end

      // delivered pixel: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        got = {out_red_out, out_green_out, out_blue_out, out_alpha_out};
        pixel_count++;
        if (shaded_q.size() == 0) begin
          note_failure($sformatf("unexpected pixel %h", got));
        end else begin
          head = shaded_q.pop_front();
          if (got.red !== head.want.red || got.green !== head.want.green ||
              got.blue !== head.want.blue || got.alpha !== head.want.alpha)
            note_failure($sformatf("mode %0d value %0d in %h exp %h got %h",
                                   head.mode, head.level, head.src, head.want, got));
        end
      end
    end
    pending_count = shaded_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the RGB effect unit testbench: clock, reset, stimulus, idling and verdict
`timescale 1ns / 1ps

module testbench;
  import rce_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 50;
  localparam int RAND_PHASES = 14;

  localparam logic [2:0] ADDR_MODE  = {REG_MODE, 2'b00};
  localparam logic [2:0] ADDR_VALUE = {REG_VALUE, 2'b00};
  // spare effect codes, pass-through
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // corner pixels, {r, g, b, a}
  localparam logic [255:0] CORNER_PIX = {
    32'h00000000, 32'hFFFFFFFF, 32'hFF00000F, 32'h00FF00F0,
    32'h0000FFAA, 32'h80808055, 32'h01FE7F01, 32'hC86432FE
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_stall;
  logic [7:0]  in_red_in, in_green_in, in_blue_in, in_alpha_in;
  logic        out_valid, out_stall;
  logic [7:0]  out_red_out, out_green_out, out_blue_out, out_alpha_out;

  int errors, pending, results;
  int idle_cycles = 0;
  int items_sent = 0;
  int settings_used = 0;
  int pat_idx = 0;
  bit gaps_on = 1'b0;
  bit stall_bursts_on = 1'b0;
  bit hold_off_req = 1'b0;

  always #2 clk = ~clk;

  rgb_color_effect_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_alpha_out (out_alpha_out)
  );

  rgb_effect_checker fx_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_alpha_out (out_alpha_out),
    .error_count   (errors),
    .pending_count (pending),
    .pixel_count   (results)
  );

  // one APB transfer: setup phase, then access until pready
  task automatic apb_access(input logic write, input logic [2:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // drain the pipe, then program and read back both registers
  task automatic set_effect(input logic [2:0] mode, input logic [7:0] level);
    in_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
    apb_access(1'b1, ADDR_MODE, {29'd0, mode});
    apb_access(1'b1, ADDR_VALUE, {24'd0, level});
    apb_access(1'b0, ADDR_MODE, '0);
    apb_access(1'b0, ADDR_VALUE, '0);
    settings_used++;
  endtask

  // offer one pixel request, with an optional gap first; returns at the falling edge
  task automatic send_pixel(input logic [31:0] px);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    {in_red_in, in_green_in, in_blue_in, in_alpha_in} = px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic run_directed(input logic [2:0] mode, input logic [7:0] level);
    set_effect(mode, level);
    repeat (2) begin
      send_pixel(CORNER_PIX[pat_idx*32 +: 32]);
      pat_idx = (pat_idx + 1) % 8;
    end
  endtask

  // random pixel; some are gray around the threshold, some saturated per channel
  task automatic send_random(input logic [7:0] near);
    logic [7:0] r, g, b, a;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    a = 8'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        r = near - 8'd1 + 8'($urandom_range(0, 2));
        g = r;
        b = r;
      end
      1: begin
        r = {8{r[0]}};
        g = {8{g[0]}};
        b = {8{b[0]}};
      end
      default: ;
    endcase
    send_pixel({r, g, b, a});
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_done = 1'b1;
      end else if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // watchdog: too long without any accepted request
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d pixels pending", IDLE_LIMIT, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned pick;
    logic [2:0]  mode;
    logic [7:0]  level;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;
    in_alpha_in = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    gaps_on = 1'b1;
    stall_bursts_on = 1'b1;

    // directed: reset setting, then each effect with its edge values
    repeat (2) begin
      send_pixel(CORNER_PIX[pat_idx*32 +: 32]);
      pat_idx = (pat_idx + 1) % 8;
    end
    run_directed(MODE_SEPIA, 8'd100);
    run_directed(MODE_SEPIA, 8'd255);     // intensity saturates
    run_directed(MODE_SEPIA, 8'd37);
    run_directed(MODE_GRAY, 8'd0);
    run_directed(MODE_INVERT, 8'd0);
    run_directed(MODE_THRESH, 8'd0);
    run_directed(MODE_THRESH, 8'd255);
    run_directed(MODE_POSTER, 8'd0);      // zero levels act as two
    run_directed(MODE_POSTER, 8'd1);
    run_directed(MODE_POSTER, 8'd255);
    run_directed(MODE_SPARE_LO, 8'd0);
    run_directed(MODE_SPARE_HI, 8'd255);

    // random phases; the last one runs without gaps or stalls
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == RAND_PHASES - 1) begin
        gaps_on = 1'b0;
        stall_bursts_on = 1'b0;
      end
      pick = $urandom_range(0, 11);
      mode = (pick > 7) ? 3'(pick - 8) : 3'(pick);
      case ($urandom_range(0, 5))
        0: level = 8'd0;
        1: level = 8'($urandom_range(1, 2));
        2: level = 8'($urandom_range(99, 101));
        3: level = 8'd255;
        default: level = 8'($urandom);
      endcase
      set_effect(mode, level);
      // long output hold while the sender keeps pushing
      if (phase == 3) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_random(level);
    end

    in_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d pixels under %0d effect settings (all modes, edge values, stalls)",
             items_sent, settings_used);
    $display("Compared %0d output pixels, %0d mismatches", results, errors);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
